/* rtl/refcount_fifo_page_replacement_macros.svh */
// ----------------------------------------------------------------------------
// refcount_fifo_page_replacement_macros
// Assertion macros shared by the page replacement RTL. They assume a clock
// named clk and an active-low reset named rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef REFCOUNT_FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define REFCOUNT_FIFO_PAGE_REPLACEMENT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define RC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfifo: implication check failed");

// Condition must never be seen
`define RC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rcfifo: forbidden condition seen");

`endif

/* rtl/rcfifo_pkg.sv */
// ----------------------------------------------------------------------------
// rcfifo_pkg
// Types and constants of the FIFO page replacement block with reference
// count aging.
// ----------------------------------------------------------------------------
package rcfifo_pkg;

  // Frame table geometry
  localparam int FRAMES         = 64;
  localparam int FIDX_W         = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W         = $clog2(FRAMES + 1);
  localparam int MAX_VADDR_BITS = 20;

  // Field widths
  localparam int PAGE_W    = 10;
  localparam int CNT_W     = 4;
  localparam int ORDER_W   = 32;
  localparam int TOTAL_W   = 32;
  localparam int FOUT_W    = 6;
  localparam int VB_W      = 5;
  localparam int CFG_FRAMES_W = 7;
  localparam int PHASE_W   = 2;

  // Port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 7;

  // Policy constants
  localparam int REF_MAX         = 10;
  localparam int REF_INIT        = 3;
  localparam int AGING_PERIOD    = 4;
  localparam int PAGE_BITS_FLOOR = 10;
  localparam logic [PHASE_W-1:0] AGING_LAST = PHASE_W'(AGING_PERIOD - 1);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VADDR_BITS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAGE_BITS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAMES     = 2'd2;

  // One frame table entry
  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               dirty;
    logic [CNT_W-1:0]   cnt;
    logic [PAGE_W-1:0]  page;
  } frame_entry_t;

  // Frame table write port
  typedef struct packed {
    logic              en;
    logic [FIDX_W-1:0] addr;
    frame_entry_t      data;
  } mem_wr_t;

  // Operations of the shared frame unit
  typedef enum logic {
    OP_HIT,
    OP_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    frame_entry_t       entry;
    logic [PAGE_W-1:0]  page;
    logic [CNT_W-1:0]   amount;
    logic               is_write;
    logic [ORDER_W-1:0] next_order;
    logic [ORDER_W-1:0] best_age;
    logic               have;
  } alu_in_t;

  typedef struct packed {
    frame_entry_t       wr_entry;
    logic               page_match;
    logic               cnt_lt;
    logic               cnt_zero;
    logic [ORDER_W-1:0] age;
    logic               older;
  } alu_out_t;

endpackage

/* rtl/rcfifo_frame_mem.sv */
// ----------------------------------------------------------------------------
// rcfifo_frame_mem
// Frame table: one write port, one registered read port, and a valid flag
// per frame held in flops so that reset empties the table at once.
// ----------------------------------------------------------------------------
module rcfifo_frame_mem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [rcfifo_pkg::FIDX_W-1:0]        rd_addr,
  output rcfifo_pkg::frame_entry_t             rd_data,
  input  rcfifo_pkg::mem_wr_t                  wr,
  input  logic [rcfifo_pkg::FIDX_W-1:0]        vld_idx,
  output logic                                 vld_bit
);
  import rcfifo_pkg::*;

  frame_entry_t             frame_mem_r [FRAMES];
  frame_entry_t             rd_data_r;
  logic [FRAMES-1:0]        valid_r;

  // Storage, read data registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      frame_mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= frame_mem_r[rd_addr];
    end
  end

  // A frame turns valid on its first write and stays so
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign vld_bit = valid_r[vld_idx];

endmodule

/* rtl/rcfifo_frame_alu.sv */
// ----------------------------------------------------------------------------
// rcfifo_frame_alu
// Shared per-frame unit: page compare, count increment or aging subtract,
// and the load-age compare used to pick the oldest zero-count frame.
// ----------------------------------------------------------------------------
module rcfifo_frame_alu (
  input  rcfifo_pkg::alu_in_t  alu_i,
  output rcfifo_pkg::alu_out_t alu_o
);
  import rcfifo_pkg::*;

  logic [CNT_W-1:0]   cnt_sub;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ORDER_W-1:0] age;

  // Saturating count arithmetic
  assign cnt_sub = (alu_i.entry.cnt > alu_i.amount) ? (alu_i.entry.cnt - alu_i.amount) : '0;
  assign cnt_inc = (alu_i.entry.cnt < CNT_W'(REF_MAX)) ? (alu_i.entry.cnt + CNT_W'(1))
                                                       : alu_i.entry.cnt;

  // Age wraps modulo 2^32
  assign age = alu_i.next_order - alu_i.entry.order;

  always_comb begin
    alu_o.wr_entry = alu_i.entry;
    case (alu_i.op)
      OP_HIT: begin
        alu_o.wr_entry.cnt   = cnt_inc;
        alu_o.wr_entry.dirty = alu_i.entry.dirty | alu_i.is_write;
      end
      OP_SUB: begin
        alu_o.wr_entry.cnt = cnt_sub;
      end
      default: begin
        alu_o.wr_entry.cnt = alu_i.entry.cnt;
      end
    endcase
    alu_o.page_match = (alu_i.entry.page == alu_i.page);
    alu_o.cnt_lt     = (alu_i.entry.cnt < alu_i.amount);
    alu_o.cnt_zero   = (cnt_sub == '0);
    alu_o.age        = age;
    alu_o.older      = !alu_i.have || (age > alu_i.best_age);
  end

endmodule

/* rtl/refcount_fifo_page_replacement.sv */
// ----------------------------------------------------------------------------
// refcount_fifo_page_replacement
// Flow: an out-of-range address goes straight to the result; a hit ends
// the scan of the n active frames; a fill installs into an empty frame; an
// eviction adds a sweep that ages counts and picks the victim. Every fourth
// handled access adds an aging pass. One item in flight: the next is taken
// once the result is registered. Sync active-low reset empties frames, clears counters.
// ----------------------------------------------------------------------------
`include "refcount_fifo_page_replacement_macros.svh"

module refcount_fifo_page_replacement (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: virtual_address [19:0], zero [23:20]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rcfifo_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: is_write [0]
  input  logic                                  in_tuser,
  // out_tdata: hit [0], filled_empty [1], replaced [2], victim_dirty [3],
  // frame_slot [9:4], victim_page [19:10], address_error [20],
  // access_total [52:21], fault_total [84:53], disk_write_total [116:85]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rcfifo_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                  cfg_we,
  input  logic [rcfifo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rcfifo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rcfifo_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_INSTALL,
    ST_BOOK,
    ST_AGE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [VB_W-1:0]         cfg_vbits_r;
  logic [VB_W-1:0]         cfg_pbits_r;
  logic [CFG_FRAMES_W-1:0] cfg_frames_r;

  // Current item
  logic [MAX_VADDR_BITS-1:0] addr_r;
  logic                      wr_r;
  logic [PAGE_W-1:0]         page_r;
  logic [FCNT_W-1:0]         n_r;

  // Sweep pipeline
  logic [FCNT_W-1:0] rd_cnt_r;
  logic              p_vld_r;
  logic [FIDX_W-1:0] p_idx_r;

  // Per-item results
  logic               hit_r, filled_r, repl_r, vdirty_r, err_r;
  logic               empty_found_r, have_r;
  logic [FIDX_W-1:0]  fidx_r;
  logic [PAGE_W-1:0]  vpage_r;
  logic [CNT_W-1:0]   minc_r;
  logic [ORDER_W-1:0] best_age_r;

  // Persistent state
  logic [ORDER_W-1:0] next_order_r;
  logic [PHASE_W-1:0] phase_r;
  logic [TOTAL_W-1:0] access_r, fault_r, disk_r;

  // Output register
  logic               out_tvalid_r;
  logic               out_hit_r, out_filled_r, out_repl_r, out_vdirty_r, out_err_r;
  logic [FOUT_W-1:0]  out_fidx_r;
  logic [PAGE_W-1:0]  out_vpage_r;
  logic [TOTAL_W-1:0] out_access_r, out_fault_r, out_disk_r;

  // Combinational helpers
  logic [VB_W-1:0]     vbits_eff, pbits_eff;
  logic [FCNT_W-1:0]   n_eff;
  logic                addr_err;
  logic [PAGE_W-1:0]   page_new;
  logic                pass_state, issue, pass_last, scan_match, out_load;
  frame_entry_t        rd_data;
  logic                vld_bit;
  mem_wr_t             mem_wr;
  alu_in_t             alu_in;
  alu_out_t            alu_out;

  // Clamp configuration to its working ranges
  always_comb begin
    if (cfg_vbits_r < VB_W'(PAGE_BITS_FLOOR)) begin
      vbits_eff = VB_W'(PAGE_BITS_FLOOR);
    end else if (cfg_vbits_r > VB_W'(MAX_VADDR_BITS)) begin
      vbits_eff = VB_W'(MAX_VADDR_BITS);
    end else begin
      vbits_eff = cfg_vbits_r;
    end
    if (cfg_pbits_r < VB_W'(PAGE_BITS_FLOOR)) begin
      pbits_eff = VB_W'(PAGE_BITS_FLOOR);
    end else if (cfg_pbits_r > vbits_eff) begin
      pbits_eff = vbits_eff;
    end else begin
      pbits_eff = cfg_pbits_r;
    end
    if (cfg_frames_r == '0) begin
      n_eff = FCNT_W'(1);
    end else if (cfg_frames_r > CFG_FRAMES_W'(FRAMES)) begin
      n_eff = FCNT_W'(FRAMES);
    end else begin
      n_eff = FCNT_W'(cfg_frames_r);
    end
  end

  assign addr_err = ((addr_r >> vbits_eff) != '0);
  assign page_new = PAGE_W'(addr_r >> pbits_eff);

  // Sweep control: one frame read issued per cycle
  assign pass_state = (state_r == ST_SCAN) || (state_r == ST_EVICT) || (state_r == ST_AGE);
  assign issue      = pass_state && (rd_cnt_r < n_r);
  assign pass_last  = p_vld_r && (p_idx_r == FIDX_W'(n_r - FCNT_W'(1)));

  rcfifo_frame_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (issue),
    .rd_addr (rd_cnt_r[FIDX_W-1:0]),
    .rd_data (rd_data),
    .wr      (mem_wr),
    .vld_idx (p_idx_r),
    .vld_bit (vld_bit)
  );

  // Shared frame unit
  always_comb begin
    alu_in.op         = (state_r == ST_SCAN) ? OP_HIT : OP_SUB;
    alu_in.entry      = rd_data;
    alu_in.page       = page_r;
    alu_in.amount     = (state_r == ST_AGE) ? CNT_W'(1) : minc_r;
    alu_in.is_write   = wr_r;
    alu_in.next_order = next_order_r;
    alu_in.best_age   = best_age_r;
    alu_in.have       = have_r;
  end

  rcfifo_frame_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  assign scan_match = p_vld_r && vld_bit && alu_out.page_match;

  // Frame table write selection
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = p_idx_r;
    mem_wr.data = alu_out.wr_entry;
    case (state_r)
      ST_SCAN:    mem_wr.en = scan_match;
      ST_EVICT:   mem_wr.en = p_vld_r;
      ST_AGE:     mem_wr.en = p_vld_r && vld_bit;
      ST_INSTALL: begin
        mem_wr.en         = 1'b1;
        mem_wr.addr       = fidx_r;
        mem_wr.data.page  = page_r;
        mem_wr.data.cnt   = CNT_W'(REF_INIT);
        mem_wr.data.dirty = wr_r;
        mem_wr.data.order = next_order_r;
      end
      default: mem_wr.en = 1'b0;
    endcase
  end

  assign out_load = (state_r == ST_FINISH) && (!out_tvalid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = addr_err ? ST_FINISH : ST_SCAN;
      ST_SCAN: begin
        if (scan_match) begin
          state_nxt = ST_BOOK;
        end else if (pass_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE:  state_nxt = empty_found_r ? ST_INSTALL : ST_EVICT;
      ST_EVICT:   if (pass_last) state_nxt = ST_INSTALL;
      ST_INSTALL: state_nxt = ST_BOOK;
      ST_BOOK:    state_nxt = (phase_r == AGING_LAST) ? ST_AGE : ST_FINISH;
      ST_AGE:     if (pass_last) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // State, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_vbits_r  <= VB_W'(20);
      cfg_pbits_r  <= VB_W'(12);
      cfg_frames_r <= CFG_FRAMES_W'(8);
      n_r          <= FCNT_W'(1);
      rd_cnt_r     <= '0;
      p_vld_r      <= 1'b0;
      next_order_r <= '0;
      phase_r      <= '0;
      access_r     <= '0;
      fault_r      <= '0;
      disk_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_VADDR_BITS: cfg_vbits_r  <= cfg_wdata[VB_W-1:0];
          REG_PAGE_BITS:  cfg_pbits_r  <= cfg_wdata[VB_W-1:0];
          REG_FRAMES:     cfg_frames_r <= cfg_wdata[CFG_FRAMES_W-1:0];
          default: ;
        endcase
      end

      // Sweep counter and read pipeline
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + FCNT_W'(1);
      end else if (!pass_state) begin
        rd_cnt_r <= '0;
      end
      p_vld_r <= issue;
      p_idx_r <= rd_cnt_r[FIDX_W-1:0];

      // Result valid: set on load, cleared once taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            addr_r <= in_tdata[MAX_VADDR_BITS-1:0];
            wr_r   <= in_tuser;
          end
        end
        ST_CHECK: begin
          n_r           <= n_eff;
          page_r        <= page_new;
          err_r         <= addr_err;
          hit_r         <= 1'b0;
          filled_r      <= 1'b0;
          repl_r        <= 1'b0;
          vdirty_r      <= 1'b0;
          fidx_r        <= '0;
          vpage_r       <= '0;
          empty_found_r <= 1'b0;
          have_r        <= 1'b0;
          minc_r        <= '1;
          best_age_r    <= '0;
        end
        ST_SCAN: begin
          // Lowest matching frame wins; otherwise note the lowest empty one
          if (p_vld_r) begin
            if (vld_bit && alu_out.page_match) begin
              hit_r  <= 1'b1;
              fidx_r <= p_idx_r;
            end else if (!vld_bit && !empty_found_r) begin
              empty_found_r <= 1'b1;
              fidx_r        <= p_idx_r;
            end
            if (vld_bit && alu_out.cnt_lt) begin
              minc_r <= rd_data.cnt;
            end
          end
        end
        ST_DECIDE: begin
          if (empty_found_r) begin
            filled_r <= 1'b1;
          end
        end
        ST_EVICT: begin
          // Drop all counts by the minimum, keep the oldest zero-count frame
          if (p_vld_r && alu_out.cnt_zero && alu_out.older) begin
            have_r     <= 1'b1;
            best_age_r <= alu_out.age;
            fidx_r     <= p_idx_r;
            vpage_r    <= rd_data.page;
            vdirty_r   <= rd_data.dirty;
          end
          if (pass_last) begin
            repl_r <= 1'b1;
          end
        end
        ST_INSTALL: begin
          next_order_r <= next_order_r + ORDER_W'(1);
          if (repl_r) begin
            fault_r <= fault_r + TOTAL_W'(1);
            if (vdirty_r) begin
              disk_r <= disk_r + TOTAL_W'(1);
            end
          end
        end
        ST_BOOK: begin
          access_r <= access_r + TOTAL_W'(1);
          if (phase_r == AGING_LAST) begin
            phase_r <= '0;
          end else begin
            phase_r <= phase_r + PHASE_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_hit_r    <= hit_r;
            out_filled_r <= filled_r;
            out_repl_r   <= repl_r;
            out_vdirty_r <= vdirty_r;
            out_err_r    <= err_r;
            out_fidx_r   <= FOUT_W'(fidx_r);
            out_vpage_r  <= vpage_r;
            out_access_r <= access_r;
            out_fault_r  <= fault_r;
            out_disk_r   <= disk_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_disk_r, out_fault_r, out_access_r, out_err_r,
                       out_vpage_r, out_fidx_r, out_vdirty_r, out_repl_r,
                       out_filled_r, out_hit_r};

  // Checks
  `RC_ASSERT_IMPL(a_result_onehot, out_tvalid_r, ($onehot({out_hit_r, out_filled_r, out_repl_r, out_err_r})))
  `RC_ASSERT_IMPL(a_vdirty_needs_repl, out_tvalid_r && out_vdirty_r, out_repl_r)
  `RC_ASSERT_IMPL(a_sweep_idx_range, p_vld_r, ({1'b0, p_idx_r} < n_r))
  `RC_ASSERT_IMPL(a_install_has_victim, (state_r == ST_INSTALL) && repl_r, have_r)
  `RC_ASSERT_NEVER(a_no_write_when_idle, mem_wr.en && ((state_r == ST_IDLE) || (state_r == ST_FINISH)))

endmodule

/* dv/tb_refcount_fifo_page_replacement.sv */
// ----------------------------------------------------------------------------
// tb_refcount_fifo_page_replacement
// Self-checking bench for the FIFO page replacement block with reference
// count aging. A queue of memory accesses feeds a clocked stream driver; every
// accepted access is run through a local frame table model and the predicted
// outcome is queued. A clocked monitor checks each result item against the
// oldest prediction. Phases step through several address, page size and
// frame count settings, including out-of-range ones that must clamp, with
// different patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_refcount_fifo_page_replacement;
  import rcfifo_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;

  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_mode_t;

  // One memory access
  typedef struct packed {
    logic [19:0] addr;
    logic        wr;
  } access_t;

  // Result item, laid out as out_tdata (lowest field last)
  typedef struct packed {
    logic [2:0]         pad;
    logic [TOTAL_W-1:0] disk_writes;
    logic [TOTAL_W-1:0] faults;
    logic [TOTAL_W-1:0] accesses;
    logic               addr_err;
    logic [PAGE_W-1:0]  victim_page;
    logic [FOUT_W-1:0]  frame_idx;
    logic               victim_dirty;
    logic               replaced;
    logic               filled_empty;
    logic               hit;
  } page_outcome_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies, reset values
  logic [4:0] vbits_cfg  = 5'd20;
  logic [4:0] pbits_cfg  = 5'd12;
  logic [6:0] frames_cfg = 7'd8;

  // Frame table as the block should hold it
  bit                 fr_valid [FRAMES];
  logic [PAGE_W-1:0]  fr_page  [FRAMES];
  int unsigned        fr_cnt   [FRAMES];
  bit                 fr_dirty [FRAMES];
  bit [ORDER_W-1:0]   fr_order [FRAMES];
  bit [ORDER_W-1:0]   load_seq;
  int unsigned        aging_ph;
  bit [TOTAL_W-1:0]   access_tot;
  bit [TOTAL_W-1:0]   fault_tot;
  bit [TOTAL_W-1:0]   diskwr_tot;

  access_t       access_q[$];
  page_outcome_t outcome_q[$];
  access_t       next_access;
  page_outcome_t got_outcome;
  page_outcome_t want_outcome;
  flow_mode_t    flow = FLOW_FREE;
  int            items_sent   = 0;
  int            results_seen = 0;
  int            fail_count   = 0;
  int            quiet_cycles = 0;

  refcount_fifo_page_replacement DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective geometry after clamping of the registers
  function automatic void eff_geometry(output int unsigned vb, output int unsigned pb,
                                       output int unsigned n);
    vb = vbits_cfg;
    if (vb < PAGE_BITS_FLOOR) vb = PAGE_BITS_FLOOR;
    if (vb > MAX_VADDR_BITS) vb = MAX_VADDR_BITS;
    pb = pbits_cfg;
    if (pb < PAGE_BITS_FLOOR) pb = PAGE_BITS_FLOOR;
    if (pb > vb) pb = vb;
    n = frames_cfg;
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
  endfunction

  // Lower counts of valid active frames, not below zero
  function automatic void drop_counts(input int unsigned n, input int unsigned amount);
    for (int i = 0; i < n; i++) begin
      if (fr_valid[i]) fr_cnt[i] = (fr_cnt[i] > amount) ? fr_cnt[i] - amount : 0;
    end
  endfunction

  // Work out the outcome of one access and update the frame table
  function automatic void resolve_access(input logic [19:0] addr, input logic wr);
    page_outcome_t o;
    int unsigned   vb, pb, n, minc, fidx;
    logic [PAGE_W-1:0] pg;
    bit [ORDER_W-1:0]  age, best_age;
    bit found, have;
    o = '0;
    found = 1'b0;
    have = 1'b0;
    fidx = 0;
    best_age = '0;
    eff_geometry(vb, pb, n);
    if (32'(addr) >= (32'd1 << vb)) begin
      o.addr_err = 1'b1;
    end else begin
      pg = PAGE_W'(32'(addr) >> pb);
      // lowest matching frame is the hit
      for (int i = 0; i < n; i++) begin
        if (!found && fr_valid[i] && fr_page[i] == pg) begin
          fidx = i;
          found = 1'b1;
        end
      end
      if (found) begin
        o.hit = 1'b1;
        if (fr_cnt[fidx] < REF_MAX) fr_cnt[fidx]++;
        if (wr) fr_dirty[fidx] = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          if (!found && !fr_valid[i]) begin
            fidx = i;
            found = 1'b1;
          end
        end
        if (found) begin
          o.filled_empty = 1'b1;
        end else begin
          // all active frames full: age until some count is zero
          minc = 32'hFFFF_FFFF;
          for (int i = 0; i < n; i++) if (fr_cnt[i] < minc) minc = fr_cnt[i];
          if (minc > 0) drop_counts(n, minc);
          // oldest load among zero counts, lowest frame on a tie
          for (int i = 0; i < n; i++) begin
            if (fr_cnt[i] == 0) begin
              age = load_seq - fr_order[i];
              if (!have || age > best_age) begin
                best_age = age;
                fidx = i;
                have = 1'b1;
              end
            end
          end
          o.replaced     = 1'b1;
          o.victim_page  = fr_page[fidx];
          o.victim_dirty = fr_dirty[fidx];
          fault_tot++;
          if (fr_dirty[fidx]) diskwr_tot++;
        end
        fr_valid[fidx] = 1'b1;
        fr_page[fidx]  = pg;
        fr_cnt[fidx]   = REF_INIT;
        fr_dirty[fidx] = wr;
        fr_order[fidx] = load_seq;
        load_seq++;
      end
      o.frame_idx = FOUT_W'(fidx);
      access_tot++;
      if (aging_ph >= AGING_PERIOD - 1) begin
        drop_counts(n, 1);
        aging_ph = 0;
      end else begin
        aging_ph++;
      end
    end
    o.accesses    = access_tot;
    o.faults      = fault_tot;
    o.disk_writes = diskwr_tot;
    outcome_q.push_back(o);
  endfunction

  function automatic string outcome_text(input page_outcome_t o);
    return $sformatf({"hit=%0d fill=%0d repl=%0d vdirty=%0d frame=%0d vpage=%0d",
                      " err=%0d acc=%0d flt=%0d dw=%0d"},
                     o.hit, o.filled_empty, o.replaced, o.victim_dirty, o.frame_idx,
                     o.victim_page, o.addr_err, o.accesses, o.faults, o.disk_writes);
  endfunction

  // Driver: present pending accesses, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) resolve_access(in_tdata[19:0], in_tuser);
      if (!in_tvalid || in_tready) begin
        if (access_q.size() > 0 &&
            $urandom_range(0, 99) >= ((flow == FLOW_SEND_IDLE) ? 53 :
                                      (flow == FLOW_BOTH) ? 35 : 0)) begin
          next_access = access_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'd0, next_access.addr};
          in_tuser  <= next_access.wr;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_outcome = page_outcome_t'(out_tdata);
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result with no access pending: %s",
                                         outcome_text(got_outcome));
        end else begin
          want_outcome = outcome_q.pop_front();
          results_seen++;
          if (got_outcome.hit          !== want_outcome.hit          ||
              got_outcome.filled_empty !== want_outcome.filled_empty ||
              got_outcome.replaced     !== want_outcome.replaced     ||
              got_outcome.victim_dirty !== want_outcome.victim_dirty ||
              got_outcome.frame_idx    !== want_outcome.frame_idx    ||
              got_outcome.victim_page  !== want_outcome.victim_page  ||
              got_outcome.addr_err     !== want_outcome.addr_err     ||
              got_outcome.accesses     !== want_outcome.accesses     ||
              got_outcome.faults       !== want_outcome.faults       ||
              got_outcome.disk_writes  !== want_outcome.disk_writes) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d expected: %s", results_seen, outcome_text(want_outcome));
              $display("result %0d actual:   %s", results_seen, outcome_text(got_outcome));
            end
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= ((flow == FLOW_RECV_STALL) ? 53 :
                                               (flow == FLOW_BOTH) ? 35 : 0));
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("refcount_fifo_page_replacement: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_access(input logic [19:0] addr, input logic wr);
    access_t a;
    a.addr = addr;
    a.wr   = wr;
    access_q.push_back(a);
    items_sent++;
  endtask

  // Random accesses: mostly a working set a bit larger than the frame count
  task automatic add_random(input int count);
    int unsigned vb, pb, n, lim, pages, ws, base, r, pg;
    logic [19:0] addr;
    eff_geometry(vb, pb, n);
    lim   = 32'd1 << vb;
    pages = 32'd1 << (vb - pb);
    ws    = n + n / 2 + 2;
    if (ws > pages) ws = pages;
    base  = $urandom_range(0, pages - 1);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (vb < MAX_VADDR_BITS && r < 10) begin
        addr = 20'($urandom_range(20'hFFFFF, lim));
      end else if (r < 20) begin
        addr = 20'($urandom_range(lim - 1, 0));
      end else begin
        // occasionally move the working set
        if (r < 23) base = $urandom_range(0, pages - 1);
        pg   = (base + $urandom_range(0, ws - 1)) % pages;
        addr = 20'((pg << pb) | ($urandom & ((32'd1 << pb) - 1)));
      end
      push_access(addr, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VADDR_BITS: vbits_cfg  = val[4:0];
      REG_PAGE_BITS:  pbits_cfg  = val[4:0];
      REG_FRAMES:     frames_cfg = val;
      default: ;
    endcase
  endtask

  // New settings, only once every pending result is back
  task automatic configure(input logic [6:0] vb, input logic [6:0] pb, input logic [6:0] fr);
    drain();
    write_reg(REG_VADDR_BITS, vb);
    write_reg(REG_PAGE_BITS, pb);
    write_reg(REG_FRAMES, fr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: fills, hits, saturation, dirty and clean evictions
    flow = FLOW_FREE;
    push_access(20'h00000, 1'b0);
    push_access(20'hFFFFF, 1'b1);
    push_access(20'h00FFF, 1'b1);
    for (int k = 0; k < 10; k++) push_access(20'(k * 97), 1'b0);
    for (int p = 1; p <= 6; p++) push_access(20'(p << 12), 1'(p & 1));
    for (int p = 7; p <= 10; p++) push_access(20'((p << 12) | 12'hABC), 1'b0);
    add_random(170);

    // Small address space, two frames: limit edges
    configure(7'd12, 7'd10, 7'd2);
    flow = FLOW_SEND_IDLE;
    push_access(20'h01000, 1'b0);
    push_access(20'h00FFF, 1'b1);
    push_access(20'hFFFFF, 1'b1);
    push_access(20'h00000, 1'b0);
    add_random(110);

    // Smallest pages, all frames
    configure(7'd20, 7'd10, 7'd64);
    flow = FLOW_RECV_STALL;
    add_random(140);

    // Fewer frames: the rest keep their contents
    configure(7'd20, 7'd14, 7'd4);
    flow = FLOW_BOTH;
    add_random(110);

    // Grow again over stale frames
    configure(7'd20, 7'd12, 7'd12);
    flow = FLOW_FREE;
    add_random(110);

    // Values below range clamp to minimum
    configure(7'd0, 7'd31, 7'd0);
    flow = FLOW_SEND_IDLE;
    add_random(80);

    // Values above range clamp to maximum
    configure(7'd31, 7'd31, 7'd127);
    flow = FLOW_RECV_STALL;
    add_random(60);

    configure(7'd15, 7'd11, 7'd5);
    flow = FLOW_BOTH;
    add_random(120);

    configure(7'd18, 7'd13, 7'd33);
    flow = FLOW_FREE;
    add_random(110);

    // Upper write data bits are outside the 5-bit registers
    configure(7'h74, 7'h6C, 7'd8);
    flow = FLOW_BOTH;
    add_random(110);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcome_q.size() > 0) begin
      fail_count += outcome_q.size();
      $display("%0d predicted results never arrived", outcome_q.size());
    end
    if (fail_count == 0) begin
      $display("refcount_fifo_page_replacement: match");
    end else begin
      $display("refcount_fifo_page_replacement: mismatch");
    end
    $finish;
  end

endmodule
